### sv/nma_pkg.sv
// Shared types, constants and activation tables for the neuron MAC/activation unit.
package nma_pkg;

    localparam int SID_W     = 6;
    localparam int VAL_W     = 16;
    localparam int NET_W     = 32;
    localparam int ACC_W     = 38;
    localparam int MODE_W    = 3;
    localparam int FRAC_BITS = 12;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    // Interpolation table geometry: 128 segments over 0..8 in Q8.24.
    localparam int LUT_FRAC  = 20;
    localparam int LUT_IDX_W = 7;
    localparam int SAT_BIT   = 27;
    localparam int TAB_W     = 17;
    localparam int TAB_LAST  = 128;
    localparam int P_W       = 37;
    localparam int ROUND_SH  = 24;

    localparam logic [PADDR_W-3:0] REG_MODE_IDX = 1'b0;

    localparam logic [MODE_W-1:0] MODE_BIAS      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INPUT     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IDENTITY  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEAVISIDE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOGISTIC  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TANH      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_IDENTITY;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic signed [VAL_W-1:0] ONE_Q12 = 16'sd4096;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [NET_W-1:0] NET_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [NET_W-1:0] NET_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [P_W-1:0] P_ONE   = {1'b1, {(P_W-1){1'b0}}};
    localparam logic [P_W-1:0] P_ROUND = P_W'(64'd1 << (ROUND_SH - 1));

    localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;

    typedef enum logic [1:0] {
        OUT_PASS,
        OUT_BIAS,
        OUT_ACT
    } out_sel_t;

    typedef struct packed {
        logic     load_we;
        logic     capture;
        logic     acc_en;
        logic     net_en;
        logic     clear_eval;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    typedef logic [TAB_W-1:0] tab_t [0:TAB_LAST];

    // Restoring division, used only while the tables are elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Half table in Q16 at x = j/16: logistic when odd is low, tanh when high.
    function automatic tab_t build_tab(input logic odd);
        logic [63:0] e [0:256];
        logic [63:0] den;
        logic [63:0] num;
        tab_t        t;
        e[0] = 64'd1 << 30;
        for (int j = 1; j <= 256; j++) begin
            e[j] = (e[j-1] * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        for (int j = 0; j <= TAB_LAST; j++) begin
            if (!odd) begin
                den = (64'd1 << 30) + e[j];
                num = (64'd1 << 46) + (den >> 1);
            end else begin
                den = (64'd1 << 30) + e[2*j];
                num = (((64'd1 << 30) - e[2*j]) << 16) + (den >> 1);
            end
            t[j] = TAB_W'(udiv64(num, den));
        end
        return t;
    endfunction

    localparam tab_t LOGISTIC_TAB = build_tab(1'b0);
    localparam tab_t TANH_TAB     = build_tab(1'b1);

endpackage

### sv/nma_ctrl.sv
// Sequencer for weight loads, multiply-accumulate steps and the activation pipeline.
module nma_ctrl
    import nma_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  logic              s_tlast,
    input  logic [MODE_W-1:0] mode,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_NET,
        ST_LUT,
        ST_INTERP,
        ST_ROUND,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   accept;
    logic   direct_mode;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign direct_mode = (mode == MODE_BIAS) || (mode == MODE_INPUT);

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.out_sel = OUT_ACT;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_LOAD) begin
                        cmd.load_we = 1'b1;
                    end else begin
                        cmd.capture    = 1'b1;
                        last_next      = s_tlast;
                        // Pass-through and bias requests that carry last close the evaluation at once.
                        cmd.clear_eval = direct_mode && s_tlast;
                        if (mode == MODE_INPUT) begin
                            state_next = ST_EMIT;
                        end else if (mode == MODE_BIAS) begin
                            state_next = s_tlast ? ST_EMIT : ST_IDLE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = last_reg ? ST_NET : ST_IDLE;
            end
            ST_NET: begin
                cmd.net_en     = 1'b1;
                cmd.clear_eval = 1'b1;
                state_next     = ST_LUT;
            end
            ST_LUT:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (mode == MODE_BIAS) begin
                    cmd.out_sel = OUT_BIAS;
                end else if (mode == MODE_INPUT) begin
                    cmd.out_sel = OUT_PASS;
                end else begin
                    cmd.out_sel = OUT_ACT;
                end
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    a_load_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while the output register is still full");

    a_mac_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == REQ_SAMPLE && !direct_mode) |=> !s_tready)
        else $error("accumulating sample did not hold off the next request");

    a_act_pipe_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.net_en |-> ##4 (state_reg == ST_EMIT))
        else $error("activation pipeline did not reach the emit step in time");

endmodule

### sv/nma_dp.sv
// Weight store, multiply-accumulate, activation pipeline and output register.
module nma_dp
    import nma_pkg::*;
#(
    parameter int MAX_INPUTS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic [MODE_W-1:0]       mode,
    input  logic [SID_W-1:0]        in_sid,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [NET_W-1:0]        out_net,
    output logic [VAL_W-1:0]        out_act,
    output logic [VAL_W-1:0]        out_val,
    output logic                    out_err
);

    localparam int AW     = $clog2(MAX_INPUTS);
    localparam int SW     = SID_W + AW;
    localparam int CNT_W  = $clog2(2 * MAX_INPUTS);
    localparam int CONN_W = $clog2(MAX_INPUTS + 1);
    localparam logic [CNT_W-1:0]  SAMPLE_CAP = CNT_W'(2 * MAX_INPUTS - 1);
    localparam logic [SW-1:0]     DEPTH_SW   = SW'(MAX_INPUTS);
    localparam logic [CONN_W-1:0] DEPTH_CONN = CONN_W'(MAX_INPUTS);

    // Weight memory and valid bits.
    logic signed [VAL_W-1:0] wmem [MAX_INPUTS];
    logic [MAX_INPUTS-1:0]   wvalid_reg;
    logic [CONN_W-1:0]       conn_reg;

    logic [SW-1:0] wr_sid_wide, cap_sid_wide;
    logic [AW-1:0] wr_idx, cap_idx;
    logic          wr_in_range, cap_in_range;

    // Captured sample and MAC state.
    logic [SID_W-1:0]          sid_cap_reg;
    logic signed [VAL_W-1:0]   val_cap_reg;
    logic signed [VAL_W-1:0]   rd_w_reg;
    logic                      rd_ok_reg;
    logic signed [VAL_W-1:0]   w_eff;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic [CNT_W-1:0]          cnt_reg;

    // Activation pipeline.
    logic signed [NET_W-1:0]       net_sat, net_reg;
    logic                          err_reg;
    logic                          odd;
    logic [NET_W-1:0]              mag;
    logic [LUT_IDX_W-1:0]          idx;
    logic [LUT_IDX_W:0]            idx_nx;
    logic signed [NET_W-FRAC_BITS-1:0] net_floor;
    logic signed [VAL_W-1:0]       id_val;
    logic                          neg_reg, big_reg, heav_reg;
    logic [TAB_W-1:0]              h0_reg, h1_reg;
    logic [LUT_FRAC-1:0]           f_reg;
    logic signed [VAL_W-1:0]       id_reg;
    logic signed [TAB_W:0]         diff;
    logic signed [TAB_W+LUT_FRAC+1:0] slope;
    logic signed [P_W+2:0]         p_sum;
    logic [P_W-1:0]                p_reg;
    logic [P_W-1:0]                p_adj;
    logic [P_W-1:0]                p_rnd;
    logic signed [VAL_W-1:0]       r_mag;
    logic signed [VAL_W-1:0]       tab_reg;

    // Result register.
    logic                    out_valid_reg;
    logic [NET_W-1:0]        out_net_reg,  out_net_next;
    logic [VAL_W-1:0]        out_act_reg,  out_act_next;
    logic [VAL_W-1:0]        out_val_reg,  out_val_next;
    logic                    out_err_reg,  out_err_next;
    logic signed [VAL_W-1:0] act_sel;

    assign wr_sid_wide  = SW'(in_sid);
    assign cap_sid_wide = SW'(sid_cap_reg);
    assign wr_idx       = wr_sid_wide[AW-1:0];
    assign cap_idx      = cap_sid_wide[AW-1:0];
    assign wr_in_range  = wr_sid_wide < DEPTH_SW;
    assign cap_in_range = cap_sid_wide < DEPTH_SW;

    always_ff @(posedge aclk) begin
        if (cmd.load_we && wr_in_range) begin
            wmem[wr_idx] <= in_value;
        end
        rd_w_reg <= wmem[cap_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg <= '0;
            conn_reg   <= '0;
        end else if (cmd.load_we && wr_in_range) begin
            wvalid_reg[wr_idx] <= 1'b1;
            if (!wvalid_reg[wr_idx]) begin
                conn_reg <= conn_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sid_cap_reg <= in_sid;
            val_cap_reg <= in_value;
        end
        // An unloaded or out-of-range source reads as weight zero.
        rd_ok_reg <= cap_in_range && wvalid_reg[cap_idx];
        prod_reg  <= val_cap_reg * w_eff;
    end

    assign w_eff   = rd_ok_reg ? rd_w_reg : '0;
    assign acc_sum = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(prod_reg);

    always_comb begin
        if (acc_sum > (ACC_W+1)'(ACC_MAX)) begin
            acc_sat = ACC_MAX;
        end else if (acc_sum < (ACC_W+1)'(ACC_MIN)) begin
            acc_sat = ACC_MIN;
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        if (acc_reg > ACC_W'(NET_MAX)) begin
            net_sat = NET_MAX;
        end else if (acc_reg < ACC_W'(NET_MIN)) begin
            net_sat = NET_MIN;
        end else begin
            net_sat = acc_reg[NET_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.clear_eval) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_sat;
            if (cnt_reg < SAMPLE_CAP) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.net_en) begin
            net_reg <= net_sat;
            err_reg <= (cnt_reg != CNT_W'(conn_reg));
        end
    end

    // Table lookup stage: magnitude, segment index and fraction.
    assign odd       = (mode == MODE_TANH);
    assign mag       = net_reg[NET_W-1] ? (~net_reg + 1'b1) : net_reg;
    assign idx       = mag[LUT_FRAC+LUT_IDX_W-1:LUT_FRAC];
    assign idx_nx    = {1'b0, idx} + 1'b1;
    assign net_floor = net_reg[NET_W-1:FRAC_BITS];

    always_comb begin
        if (net_floor > (NET_W-FRAC_BITS)'(VAL_MAX)) begin
            id_val = VAL_MAX;
        end else if (net_floor < (NET_W-FRAC_BITS)'(VAL_MIN)) begin
            id_val = VAL_MIN;
        end else begin
            id_val = net_floor[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= net_reg[NET_W-1];
        big_reg  <= |mag[NET_W-1:SAT_BIT];
        heav_reg <= (net_reg > 0);
        h0_reg   <= odd ? TANH_TAB[idx] : LOGISTIC_TAB[idx];
        h1_reg   <= odd ? TANH_TAB[idx_nx] : LOGISTIC_TAB[idx_nx];
        f_reg    <= mag[LUT_FRAC-1:0];
        id_reg   <= id_val;
    end

    // Interpolation stage: h0 * 2^20 + (h1 - h0) * f.
    assign diff  = $signed({1'b0, h1_reg}) - $signed({1'b0, h0_reg});
    assign slope = diff * $signed({1'b0, f_reg});
    assign p_sum = $signed({3'b000, h0_reg, {LUT_FRAC{1'b0}}}) + (P_W+3)'(slope);

    always_ff @(posedge aclk) begin
        p_reg <= big_reg ? P_ONE : p_sum[P_W-1:0];
    end

    // Rounding stage: mirror for logistic, round half up, negate for tanh.
    assign p_adj = (!odd && neg_reg) ? (P_ONE - p_reg) : p_reg;
    assign p_rnd = p_adj + P_ROUND;
    assign r_mag = VAL_W'(p_rnd[P_W-1:ROUND_SH]);

    always_ff @(posedge aclk) begin
        tab_reg <= (odd && neg_reg) ? -r_mag : r_mag;
    end

    always_comb begin
        case (mode) inside
            MODE_HEAVISIDE:            act_sel = heav_reg ? ONE_Q12 : '0;
            MODE_LOGISTIC, MODE_TANH:  act_sel = tab_reg;
            default:                   act_sel = id_reg;
        endcase
    end

    always_comb begin
        case (cmd.out_sel)
            OUT_PASS: begin
                out_net_next = {{(NET_W-VAL_W-FRAC_BITS){val_cap_reg[VAL_W-1]}},
                                val_cap_reg, {FRAC_BITS{1'b0}}};
                out_act_next = val_cap_reg;
                out_val_next = val_cap_reg;
                out_err_next = 1'b0;
            end
            OUT_BIAS: begin
                out_net_next = '0;
                out_act_next = '0;
                out_val_next = ONE_Q12;
                out_err_next = 1'b0;
            end
            default: begin
                out_net_next = net_reg;
                out_act_next = act_sel;
                out_val_next = act_sel;
                out_err_next = err_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_net_reg <= out_net_next;
            out_act_reg <= out_act_next;
            out_val_reg <= out_val_next;
            out_err_reg <= out_err_next;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign out_net       = out_net_reg;
    assign out_act       = out_act_reg;
    assign out_val       = out_val_reg;
    assign out_err       = out_err_reg;

    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result did not appear on the output");

    a_count_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SAMPLE_CAP)
        else $error("sample count passed its saturation limit");

    a_conn_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(wvalid_reg) == int'(conn_reg) && conn_reg <= DEPTH_CONN)
        else $error("connection count disagrees with the weight valid bits");

endmodule

### sv/neuron_mac_activation_unit.sv
// Neuron engine top level: stream ports, mode register, controller and datapath.
// Weight load: the block stays ready for the next request. Accumulating sample: the next
// request waits on the weight memory read, product register and saturating accumulator add.
// Closing sample: net register, lookup, interpolation and rounding stages, then the output
// register once it is free. Input requests and closing bias requests also wait for it.
// Reset (synchronous, aresetn low) clears all weight valid bits and counts; mode = identity.
module neuron_mac_activation_unit
    import nma_pkg::*;
#(
    parameter int MAX_INPUTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [5:0] source_id, [21:6] value, [23:22] zero
    input  logic                 s_tuser,   // [0] req_type
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] net_input, [47:32] activated,
                                            // [63:48] output_value
    output logic                 m_tuser,   // [0] count_error
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic [MODE_W-1:0] mode_reg;
    logic              mode_sel;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [NET_W-1:0]  out_net;
    logic [VAL_W-1:0]  out_act;
    logic [VAL_W-1:0]  out_val;

    assign pready   = 1'b1;
    assign mode_sel = (paddr[PADDR_W-1:2] == REG_MODE_IDX);
    assign prdata   = mode_sel ? PDATA_W'(mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (psel && penable && pwrite && pready && mode_sel) begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    nma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .mode     (mode_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    nma_dp #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .mode     (mode_reg),
        .in_sid   (s_tdata[SID_W-1:0]),
        .in_value (s_tdata[SID_W+VAL_W-1:SID_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_net  (out_net),
        .out_act  (out_act),
        .out_val  (out_val),
        .out_err  (m_tuser)
    );

    assign m_tdata = {out_val, out_act, out_net};

endmodule

### verif/tb_top.sv
// Self-checking stream testbench for the neuron MAC and activation unit.
`timescale 1ns / 1ps

module tb_top
    import nma_pkg::*;
();

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_SOURCES  = 64;
    localparam int SAMPLE_CAP   = 2 * NUM_SOURCES - 1;
    localparam int TABLE_PTS    = 128;
    localparam int PHASE_ITEMS  = 50;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic [MODE_W-1:0]  MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0]  MODE_SPARE7 = 3'd7;
    localparam logic [PADDR_W-1:0] MODE_ADDR   = {REG_MODE_IDX, 2'b00};

    typedef struct {
        logic signed [NET_W-1:0] net;
        logic signed [VAL_W-1:0] act;
        logic signed [VAL_W-1:0] outv;
        logic                    cnt_err;
    } neuron_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [5:0] source_id, [21:6] value, [23:22] zero
    logic                 s_tuser;   // [0] req_type
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [31:0] net_input, [47:32] activated, [63:48] output_value
    logic                 m_tuser;   // [0] count_error
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Predicted neuron state.
    logic signed [VAL_W-1:0] wt_mem [NUM_SOURCES];
    bit                      wt_loaded [NUM_SOURCES];
    int                      links;
    longint                  acc_sum;
    int                      samples_seen;
    logic [MODE_W-1:0]       mode_reg;
    longint unsigned         sigmoid_pts [TABLE_PTS+1];
    longint unsigned         tanh_pts [TABLE_PTS+1];

    neuron_result_t expected_results [$];
    int             fail_count   = 0;
    int             items_sent   = 0;
    int             results_seen = 0;
    bit             src_gaps_on  = 1'b1;
    bit             sink_idle_on = 1'b1;
    bit             sink_hold    = 1'b0;
    event           sink_hold_go;

    neuron_mac_activation_unit #(
        .MAX_INPUTS(NUM_SOURCES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    function automatic void flag_failure(string what, longint want_v, longint got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    endfunction

    // Tables of the half curves in Q16 at x = j/16, from an integer series of e^(-j/16); also clears the model state.
    function automatic void init_neuron_model();
        longint unsigned e [2*TABLE_PTS+1];
        longint unsigned den;
        e[0] = 64'd1 << 30;
        for (int j = 1; j <= 2 * TABLE_PTS; j++) begin
            e[j] = (e[j-1] * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        for (int j = 0; j <= TABLE_PTS; j++) begin
            den = (64'd1 << 30) + e[j];
            sigmoid_pts[j] = ((64'd1 << 46) + den / 2) / den;
            den = (64'd1 << 30) + e[2*j];
            tanh_pts[j] = ((((64'd1 << 30) - e[2*j]) << 16) + den / 2) / den;
        end
        for (int i = 0; i < NUM_SOURCES; i++) begin
            wt_mem[i]    = '0;
            wt_loaded[i] = 1'b0;
        end
        links        = 0;
        acc_sum      = 0;
        samples_seen = 0;
        mode_reg     = MODE_RESET;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_q12(longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return VAL_W'(v);
    endfunction

    // Interpolated sigmoid-type activation; odd selects tanh, else logistic.
    function automatic logic signed [VAL_W-1:0] lookup_act(logic signed [NET_W-1:0] net, bit odd);
        longint unsigned mag;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned p;
        longint          r;
        bit              neg;
        neg = net < 0;
        mag = neg ? -longint'(net) : longint'(net);
        if (mag >= (64'd8 << 24)) begin
            p = 64'd1 << 36;
        end else begin
            idx  = mag >> 20;
            frac = mag & 64'hF_FFFF;
            p = (odd ? tanh_pts[idx] : sigmoid_pts[idx]) * ((64'd1 << 20) - frac)
              + (odd ? tanh_pts[idx+1] : sigmoid_pts[idx+1]) * frac;
        end
        if (!odd && neg)
            p = (64'd1 << 36) - p;
        r = longint'((p + (64'd1 << 23)) >> 24);
        if (odd && neg)
            r = -r;
        return clamp_q12(r);
    endfunction

    function automatic void predict_request(logic req, logic [SID_W-1:0] sid,
                                            logic signed [VAL_W-1:0] v, logic last);
        neuron_result_t res;
        longint         sum;
        if (req == REQ_LOAD) begin
            wt_mem[sid] = v;
            if (!wt_loaded[sid]) begin
                wt_loaded[sid] = 1'b1;
                links++;
            end
            return;
        end
        res.cnt_err = 1'b0;
        case (mode_reg)
            MODE_INPUT: begin
                res.net  = NET_W'(longint'(v) * longint'(ONE_Q12));
                res.act  = v;
                res.outv = v;
                if (last) begin
                    acc_sum      = 0;
                    samples_seen = 0;
                end
            end
            MODE_BIAS: begin
                if (!last)
                    return;
                acc_sum      = 0;
                samples_seen = 0;
                res.net      = '0;
                res.act      = '0;
                res.outv     = ONE_Q12;
            end
            default: begin
                sum = acc_sum + longint'(v) * longint'(wt_mem[sid]);
                acc_sum = sum > longint'(ACC_MAX) ? longint'(ACC_MAX)
                        : (sum < longint'(ACC_MIN) ? longint'(ACC_MIN) : sum);
                if (samples_seen < SAMPLE_CAP)
                    samples_seen++;
                if (!last)
                    return;
                res.net = acc_sum > longint'(NET_MAX) ? NET_MAX
                        : (acc_sum < longint'(NET_MIN) ? NET_MIN : NET_W'(acc_sum));
                res.cnt_err = (samples_seen != links);
                case (mode_reg)
                    MODE_HEAVISIDE: res.act = (res.net > 0) ? ONE_Q12 : '0;
                    MODE_LOGISTIC:  res.act = lookup_act(res.net, 1'b0);
                    MODE_TANH:      res.act = lookup_act(res.net, 1'b1);
                    default:        res.act = clamp_q12(longint'(res.net >>> FRAC_BITS));
                endcase
                res.outv     = res.act;
                acc_sum      = 0;
                samples_seen = 0;
            end
        endcase
        expected_results.push_back(res);
    endfunction

    // Valid stays high between back-to-back requests and only drops before a gap.
    task automatic send_request(logic req, logic [SID_W-1:0] sid,
                                logic signed [VAL_W-1:0] v, logic last);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {{(S_TDATA_W - SID_W - VAL_W){1'b0}}, v, sid};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_request(req, sid, v, last);
        items_sent++;
    endtask

    // Loads and unfinished samples give no result, so allow time for them to settle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        logic [PDATA_W-1:0] unused_rd;
        drain_block();
        apb_access(1'b1, MODE_ADDR, PDATA_W'(m), unused_rd);
        mode_reg = m;
    endtask

    task automatic check_mode_readback();
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, MODE_ADDR, '0, rd);
        if (rd !== PDATA_W'(mode_reg))
            flag_failure("mode register readback", mode_reg, rd);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return VAL_W'($urandom);
            2: return VAL_W'($urandom_range(0, 32'h2000)) - 16'sh1000;
            3: return VAL_W'($urandom_range(0, 32'h200)) - 16'sh100;
            4: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            default: return VAL_W'($urandom_range(0, 32'h8000)) - 16'sh4000;
        endcase
    endfunction

    // Mostly the small working set of sources, sometimes the top source or any source at all.
    function automatic logic [SID_W-1:0] pick_source();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return SID_W'($urandom);
        if (r == 1)
            return SID_W'(NUM_SOURCES - 1);
        return SID_W'($urandom_range(0, 7));
    endfunction

    // A well-formed evaluation has one sample per connection loaded at its start, or one if none is.
    task automatic run_evaluation(bit well_formed);
        int len;
        len = well_formed ? (links > 0 ? links : 1) : $urandom_range(1, links + 3);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_request(REQ_LOAD, SID_W'($urandom_range(0, 7)), pick_value(), 1'($urandom));
            send_request(REQ_SAMPLE, pick_source(), pick_value(), i == len - 1);
        end
    endtask

    task automatic test_mode_register();
        logic [MODE_W-1:0] codes [8] = '{MODE_BIAS, MODE_INPUT, MODE_IDENTITY, MODE_HEAVISIDE,
                                         MODE_LOGISTIC, MODE_TANH, MODE_SPARE6, MODE_SPARE7};
        check_mode_readback();
        foreach (codes[i]) begin
            set_mode(codes[i]);
            check_mode_readback();
        end
    endtask

    task automatic test_directed_modes();
        set_mode(MODE_IDENTITY);
        // Extreme weights, a reload that keeps the link count, and last set on a load.
        send_request(REQ_LOAD, 6'd0, VAL_MAX, 1'b0);
        send_request(REQ_LOAD, 6'd1, VAL_MIN, 1'b0);
        send_request(REQ_LOAD, 6'd2, 16'sh1000, 1'b0);
        send_request(REQ_LOAD, 6'd2, -16'sh1000, 1'b0);
        send_request(REQ_LOAD, 6'd63, 16'sh0001, 1'b1);
        send_request(REQ_SAMPLE, 6'd0, VAL_MIN, 1'b0);
        send_request(REQ_SAMPLE, 6'd1, VAL_MIN, 1'b0);
        send_request(REQ_SAMPLE, 6'd2, VAL_MAX, 1'b0);
        send_request(REQ_SAMPLE, 6'd63, 16'sh1234, 1'b1);
        // One large product clips the activation, and the count comes up short.
        send_request(REQ_SAMPLE, 6'd1, VAL_MIN, 1'b1);
        // Sources without a weight still count as samples.
        send_request(REQ_SAMPLE, 6'd21, 16'sh5555, 1'b0);
        send_request(REQ_SAMPLE, 6'd42, -16'sh2AAB, 1'b1);
        set_mode(MODE_HEAVISIDE);
        send_request(REQ_SAMPLE, 6'd0, 16'sh0001, 1'b1);
        send_request(REQ_SAMPLE, 6'd0, 16'sh0000, 1'b1);
        // A net input of exactly 8.0 takes the asymptote.
        set_mode(MODE_LOGISTIC);
        send_request(REQ_SAMPLE, 6'd2, 16'sh0800, 1'b1);
        send_request(REQ_SAMPLE, 6'd2, VAL_MIN, 1'b1);
        set_mode(MODE_TANH);
        send_request(REQ_SAMPLE, 6'd2, 16'sh0800, 1'b1);
        send_request(REQ_SAMPLE, 6'd1, VAL_MAX, 1'b1);
        set_mode(MODE_BIAS);
        send_request(REQ_SAMPLE, 6'd0, 16'sh1234, 1'b0);
        send_request(REQ_SAMPLE, 6'd1, 16'sh4321, 1'b1);
        set_mode(MODE_INPUT);
        send_request(REQ_SAMPLE, 6'd0, VAL_MIN, 1'b0);
        send_request(REQ_SAMPLE, 6'd5, VAL_MAX, 1'b1);
        set_mode(MODE_SPARE7);
        send_request(REQ_SAMPLE, 6'd0, 16'sh1000, 1'b1);
    endtask

    task automatic test_random_mix();
        logic [MODE_W-1:0] phase_modes [7] = '{MODE_IDENTITY, MODE_LOGISTIC, MODE_TANH,
                                               MODE_HEAVISIDE, MODE_BIAS, MODE_INPUT,
                                               MODE_SPARE6};
        int phase_end;
        foreach (phase_modes[p]) begin
            set_mode(phase_modes[p]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                src_gaps_on  = $urandom_range(0, 3) != 0;
                sink_idle_on = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 9) == 0)
                    send_request(REQ_LOAD, SID_W'($urandom_range(0, 7)), pick_value(),
                                 1'($urandom));
                run_evaluation($urandom_range(0, 4) != 0);
            end
        end
        src_gaps_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Long runs of full-scale products drive the accumulator into both limits.
    task automatic test_accumulator_saturation();
        set_mode(MODE_IDENTITY);
        src_gaps_on = 1'b0;
        send_request(REQ_LOAD, 6'd0, VAL_MIN, 1'b0);
        for (int i = 0; i < SAMPLE_CAP + 3; i++) begin
            send_request(REQ_SAMPLE, 6'd0, VAL_MIN, i == SAMPLE_CAP + 2);
        end
        set_mode(MODE_TANH);
        send_request(REQ_LOAD, 6'd1, VAL_MAX, 1'b0);
        for (int i = 0; i < SAMPLE_CAP + 3; i++) begin
            send_request(REQ_SAMPLE, 6'd1, VAL_MIN, i == SAMPLE_CAP + 2);
        end
        src_gaps_on = 1'b1;
    endtask

    task automatic test_full_store();
        logic [MODE_W-1:0] curve_modes [2] = '{MODE_LOGISTIC, MODE_TANH};
        for (int s = 0; s < NUM_SOURCES; s++) begin
            send_request(REQ_LOAD, SID_W'(s), pick_value(), 1'b0);
        end
        foreach (curve_modes[k]) begin
            set_mode(curve_modes[k]);
            for (int i = 0; i < NUM_SOURCES; i++) begin
                send_request(REQ_SAMPLE, SID_W'(i), VAL_W'($urandom_range(0, 32'h80)) - 16'sh40,
                             i == NUM_SOURCES - 1);
            end
        end
    endtask

    // The sink holds off while requests keep coming, so the block has to stall its input.
    task automatic test_backpressure();
        set_mode(MODE_INPUT);
        src_gaps_on = 1'b0;
        -> sink_hold_go;
        for (int i = 0; i < 48; i++) begin
            send_request(REQ_SAMPLE, pick_source(), pick_value(), i % 8 == 7);
        end
        src_gaps_on = 1'b1;
    endtask

    initial begin : sink_hold_timer
        forever begin
            @(sink_hold_go);
            sink_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            sink_hold = 1'b0;
        end
    end

    initial begin : result_sink
        int             stall;
        neuron_result_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0 || sink_hold) begin
                m_tready <= 1'b0;
                repeat ((stall > 0) ? stall : 1) @(posedge aclk);
                while (sink_hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            results_seen++;
            if (expected_results.size() == 0) begin
                flag_failure("result with no request pending", 0, results_seen);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.net)
                    flag_failure("net_input", want.net, $signed(m_tdata[31:0]));
                if (m_tdata[47:32] !== want.act)
                    flag_failure("activated", want.act, $signed(m_tdata[47:32]));
                if (m_tdata[63:48] !== want.outv)
                    flag_failure("output_value", want.outv, $signed(m_tdata[63:48]));
                if (m_tuser !== want.cnt_err)
                    flag_failure("count_error", want.cnt_err, m_tuser);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : test_sequence
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_LOAD;
        s_tlast  <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        init_neuron_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mode_register();
        test_directed_modes();
        test_random_mix();
        test_accumulator_saturation();
        test_full_store();
        test_backpressure();
        drain_block();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
sv/nma_pkg.sv
sv/nma_ctrl.sv
sv/nma_dp.sv
sv/neuron_mac_activation_unit.sv
verif/tb_top.sv
